// ===== hdl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths and item types for the point-to-segment closest point block.
// ----------------------------------------------------------------------------
package psc_pkg;

   // Coordinate width and fraction width of the relative position
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   // Position is unsigned Q1.FRAC_BITS, with room for exactly 1.0
   localparam int POS_BITS  = FRAC_BITS + 1;
   // Squared distance bound is 3 * (2^COORD_BITS - 1)^2
   localparam int DIST_BITS = 2 * COORD_BITS + 2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
      logic signed [COORD_BITS-1:0] query_z;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] start_z;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic signed [COORD_BITS-1:0] end_z;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] near_x;
      logic signed [COORD_BITS-1:0] near_y;
      logic signed [COORD_BITS-1:0] near_z;
      logic        [POS_BITS-1:0]   position;
      logic        [DIST_BITS-1:0]  dist_squared;
   } rsp_item_type;

endpackage

// ===== hdl/point_segment_closest_point.sv =====
// ----------------------------------------------------------------------------
// point_segment_closest_point
// Projects a query point onto a 3-D segment and returns the closest point,
// the relative position along the segment and the squared distance.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid, req_stall | req_item (query, start, end)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_item (near, position, dist)
//
//  One item enters per cycle while req_stall is low and passes
//  FRAC_BITS + 8 register stages. The depth is set by the restoring
//  divider, one quotient bit per stage.
//  Reset (synchronous, active high) clears only the valid bits of the stages.
//  All stages advance together whenever the output register is empty or its
//  item is being taken; otherwise the whole pipe holds and req_stall is raised.
//
//  Stages:
//    diff   : D = E - S and V = P - S per axis
//    mult   : V*D and D*D per axis
//    sum    : dot = sum(V*D), mag = sum(D*D)
//    class  : before-start / beyond-end flags, divider remainder seed
//    div k  : one restoring division step per stage, FRAC_BITS stages
//    scale  : alpha * D per axis
//    pick   : closest point C and position
//    square : (P - C)^2 per axis
//    out    : sum of squares into the output register
// ----------------------------------------------------------------------------
module point_segment_closest_point (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  psc_pkg::req_item_type   req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output psc_pkg::rsp_item_type   rsp_item
);

   localparam int CW    = psc_pkg::COORD_BITS;
   localparam int FB    = psc_pkg::FRAC_BITS;
   localparam int DW    = CW + 1;          // difference of two coordinates
   localparam int PW    = 2 * DW;          // product of two differences
   localparam int DOTW  = PW + 2;          // sum of three products, signed
   localparam int MAGW  = 2 * CW + 2;      // squared length, unsigned
   localparam int RW    = MAGW + 1;        // shifted remainder
   localparam int SW    = FB + 1 + DW;     // alpha * D
   localparam int PSW   = psc_pkg::POS_BITS;
   localparam int DSW   = psc_pkg::DIST_BITS;

   // Whole pipe moves when the output register can take a new item
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---------------------------------------------------------------- diff ---
   logic                 dif_vld_ff;
   logic signed [CW-1:0] dif_p_ff [3];
   logic signed [CW-1:0] dif_s_ff [3];
   logic signed [DW-1:0] dif_d_ff [3];
   logic signed [DW-1:0] dif_v_ff [3];
   logic signed [CW-1:0] req_p [3];
   logic signed [CW-1:0] req_s [3];
   logic signed [CW-1:0] req_e [3];

   assign req_p[0] = req_item.query_x;
   assign req_p[1] = req_item.query_y;
   assign req_p[2] = req_item.query_z;
   assign req_s[0] = req_item.start_x;
   assign req_s[1] = req_item.start_y;
   assign req_s[2] = req_item.start_z;
   assign req_e[0] = req_item.end_x;
   assign req_e[1] = req_item.end_y;
   assign req_e[2] = req_item.end_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dif_p_ff[i] <= req_p[i];
            dif_s_ff[i] <= req_s[i];
            dif_d_ff[i] <= DW'(req_e[i]) - DW'(req_s[i]);
            dif_v_ff[i] <= DW'(req_p[i]) - DW'(req_s[i]);
         end
      end
   end

   // ---------------------------------------------------------------- mult ---
   logic                 mul_vld_ff;
   logic signed [CW-1:0] mul_p_ff [3];
   logic signed [CW-1:0] mul_s_ff [3];
   logic signed [DW-1:0] mul_d_ff [3];
   logic signed [PW-1:0] mul_vd_ff [3];
   logic signed [PW-1:0] mul_dd_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mul_p_ff[i]  <= dif_p_ff[i];
            mul_s_ff[i]  <= dif_s_ff[i];
            mul_d_ff[i]  <= dif_d_ff[i];
            mul_vd_ff[i] <= dif_v_ff[i] * dif_d_ff[i];
            mul_dd_ff[i] <= dif_d_ff[i] * dif_d_ff[i];
         end
      end
   end

   // ----------------------------------------------------------------- sum ---
   logic                   sum_vld_ff;
   logic signed [CW-1:0]   sum_p_ff [3];
   logic signed [CW-1:0]   sum_s_ff [3];
   logic signed [DW-1:0]   sum_d_ff [3];
   logic signed [DOTW-1:0] sum_dot_ff;
   logic        [MAGW-1:0] sum_mag_ff;
   logic signed [DOTW-1:0] sum_dot_in;
   logic signed [DOTW-1:0] sum_mag_wide;

   assign sum_dot_in   = DOTW'(mul_vd_ff[0]) + DOTW'(mul_vd_ff[1]) + DOTW'(mul_vd_ff[2]);
   assign sum_mag_wide = DOTW'(mul_dd_ff[0]) + DOTW'(mul_dd_ff[1]) + DOTW'(mul_dd_ff[2]);

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_p_ff   <= mul_p_ff;
         sum_s_ff   <= mul_s_ff;
         sum_d_ff   <= mul_d_ff;
         sum_dot_ff <= sum_dot_in;
         sum_mag_ff <= sum_mag_wide[MAGW-1:0];
      end
   end

   // ------------------------------------------------- class and divider ---
   // Entry 0 is the classify stage; entry k+1 holds the item after step k.
   logic                 div_vld_ff [FB+1];
   logic                 div_lo_ff  [FB+1];
   logic                 div_hi_ff  [FB+1];
   logic [MAGW-1:0]      div_rem_ff [FB+1];
   logic [MAGW-1:0]      div_mag_ff [FB+1];
   logic [FB-1:0]        div_quo_ff [FB+1];
   logic signed [CW-1:0] div_p_ff   [FB+1][3];
   logic signed [CW-1:0] div_s_ff   [FB+1][3];
   logic signed [DW-1:0] div_d_ff   [FB+1][3];

   logic cls_lo_in;
   logic cls_hi_in;

   // Degenerate segment or projection at or before the start: clamp to S.
   // Projection at or beyond the end: clamp to E.
   assign cls_lo_in = (sum_mag_ff == '0) || sum_dot_ff[DOTW-1] || (sum_dot_ff == '0);
   assign cls_hi_in = !cls_lo_in && (sum_dot_ff >= $signed(DOTW'(sum_mag_ff)));

   always_ff @(posedge clock) begin
      if (adv) begin
         div_lo_ff[0]  <= cls_lo_in;
         div_hi_ff[0]  <= cls_hi_in;
         // Interior items have 0 < dot < mag, so dot fits the remainder
         div_rem_ff[0] <= sum_dot_ff[MAGW-1:0];
         div_mag_ff[0] <= sum_mag_ff;
         div_quo_ff[0] <= '0;
         div_p_ff[0]   <= sum_p_ff;
         div_s_ff[0]   <= sum_s_ff;
         div_d_ff[0]   <= sum_d_ff;
      end
   end

   for (genvar k = 0; k < FB; k++) begin : g_div
      logic [RW-1:0] shifted;
      logic [RW-1:0] reduced;
      logic          take;

      assign shifted = {div_rem_ff[k], 1'b0};
      assign reduced = shifted - {1'b0, div_mag_ff[k]};
      assign take    = shifted >= {1'b0, div_mag_ff[k]};

      always_ff @(posedge clock) begin
         if (adv) begin
            div_lo_ff[k+1]  <= div_lo_ff[k];
            div_hi_ff[k+1]  <= div_hi_ff[k];
            div_rem_ff[k+1] <= take ? reduced[MAGW-1:0] : shifted[MAGW-1:0];
            div_mag_ff[k+1] <= div_mag_ff[k];
            div_quo_ff[k+1] <= {div_quo_ff[k][FB-2:0], take};
            div_p_ff[k+1]   <= div_p_ff[k];
            div_s_ff[k+1]   <= div_s_ff[k];
            div_d_ff[k+1]   <= div_d_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            div_vld_ff[k+1] <= div_vld_ff[k];
         end
      end
   end

   // --------------------------------------------------------------- scale ---
   logic                 scl_vld_ff;
   logic                 scl_lo_ff;
   logic                 scl_hi_ff;
   logic [FB-1:0]        scl_quo_ff;
   logic signed [CW-1:0] scl_p_ff [3];
   logic signed [CW-1:0] scl_s_ff [3];
   logic signed [DW-1:0] scl_d_ff [3];
   logic signed [SW-1:0] scl_prod_ff [3];

   always_ff @(posedge clock) begin
      if (adv) begin
         scl_lo_ff  <= div_lo_ff[FB];
         scl_hi_ff  <= div_hi_ff[FB];
         scl_quo_ff <= div_quo_ff[FB];
         scl_p_ff   <= div_p_ff[FB];
         scl_s_ff   <= div_s_ff[FB];
         scl_d_ff   <= div_d_ff[FB];
         for (int i = 0; i < 3; i++) begin
            scl_prod_ff[i] <= $signed({1'b0, div_quo_ff[FB]}) * div_d_ff[FB][i];
         end
      end
   end

   // ---------------------------------------------------------------- pick ---
   logic                 pck_vld_ff;
   logic [PSW-1:0]       pck_pos_ff;
   logic signed [CW-1:0] pck_p_ff [3];
   logic signed [CW-1:0] pck_c_ff [3];
   logic signed [CW-1:0] pck_c_in [3];
   logic [PSW-1:0]       pck_pos_in;
   logic signed [SW-1:0] pck_step [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // Arithmetic shift floors toward minus infinity
         pck_step[i] = scl_prod_ff[i] >>> FB;
         if (scl_lo_ff) begin
            pck_c_in[i] = scl_s_ff[i];
         end else if (scl_hi_ff) begin
            pck_c_in[i] = scl_s_ff[i] + scl_d_ff[i][CW-1:0];
         end else begin
            pck_c_in[i] = scl_s_ff[i] + pck_step[i][CW-1:0];
         end
      end
      if (scl_lo_ff) begin
         pck_pos_in = '0;
      end else if (scl_hi_ff) begin
         pck_pos_in = PSW'(1) << FB;
      end else begin
         pck_pos_in = {1'b0, scl_quo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pck_pos_ff <= pck_pos_in;
         pck_p_ff   <= scl_p_ff;
         pck_c_ff   <= pck_c_in;
      end
   end

   // -------------------------------------------------------------- square ---
   logic                 sqr_vld_ff;
   logic [PSW-1:0]       sqr_pos_ff;
   logic signed [CW-1:0] sqr_c_ff [3];
   logic signed [PW-1:0] sqr_sq_ff [3];
   logic signed [DW-1:0] sqr_t [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqr_t[i] = DW'(pck_p_ff[i]) - DW'(pck_c_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqr_pos_ff <= pck_pos_ff;
         sqr_c_ff   <= pck_c_ff;
         for (int i = 0; i < 3; i++) begin
            sqr_sq_ff[i] <= sqr_t[i] * sqr_t[i];
         end
      end
   end

   // ----------------------------------------------------------------- out ---
   logic                 rsp_vld_ff;
   psc_pkg::rsp_item_type rsp_item_ff;
   logic [DSW+1:0]       out_dist_in;

   // Each square is non-negative and below 2^(2*CW), so the low bits carry it
   assign out_dist_in = (DSW+2)'(sqr_sq_ff[0][PW-2:0]) + (DSW+2)'(sqr_sq_ff[1][PW-2:0])
                      + (DSW+2)'(sqr_sq_ff[2][PW-2:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_item_ff.near_x       <= sqr_c_ff[0];
         rsp_item_ff.near_y       <= sqr_c_ff[1];
         rsp_item_ff.near_z       <= sqr_c_ff[2];
         rsp_item_ff.position     <= sqr_pos_ff;
         rsp_item_ff.dist_squared <= out_dist_in[DSW-1:0];
      end
   end

   // ---------------------------------------------------------- valid bits ---
   // Advance every valid bit with its stage; drop them all on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         dif_vld_ff    <= 1'b0;
         mul_vld_ff    <= 1'b0;
         sum_vld_ff    <= 1'b0;
         div_vld_ff[0] <= 1'b0;
         scl_vld_ff    <= 1'b0;
         pck_vld_ff    <= 1'b0;
         sqr_vld_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else if (adv) begin
         dif_vld_ff    <= req_valid;
         mul_vld_ff    <= dif_vld_ff;
         sum_vld_ff    <= mul_vld_ff;
         div_vld_ff[0] <= sum_vld_ff;
         scl_vld_ff    <= div_vld_ff[FB];
         pck_vld_ff    <= scl_vld_ff;
         sqr_vld_ff    <= pck_vld_ff;
         rsp_vld_ff    <= sqr_vld_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
